FILE: src/qpht_pkg.sv
// ----------------------------------------------------------------------------
// Hash table package
// Shared sizes, codes, the transaction type and the byte residue table.
// ----------------------------------------------------------------------------
package qpht_pkg;

	localparam int TABLE_SIZE  = 16;
	localparam int NAME_CHARS  = 16;
	localparam int NAME_BYTES  = 16;
	localparam int IDX_W       = $clog2(TABLE_SIZE);
	localparam int CNT_W       = $clog2(TABLE_SIZE + 1);
	localparam int SUM_W       = IDX_W + 4;
	localparam int SLOT_W      = 4;
	localparam int PHONE_W     = 31;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	localparam logic [1:0] ST_STORED  = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_FOUND   = 2'd2;
	localparam logic [1:0] ST_MISSING = 2'd3;

	typedef struct packed {
		logic               command;
		logic [63:0]        key_low;
		logic [63:0]        key_high;
		logic [PHONE_W-1:0] phone;
		logic [IDX_W-1:0]   home;
	} qpht_item_t;

	typedef logic [IDX_W-1:0] res_tab_t [256];

	function automatic res_tab_t build_byte_res();
		res_tab_t t;
		for (int b = 0; b < 256; b++) begin
			t[b] = IDX_W'(b % TABLE_SIZE);
		end
		return t;
	endfunction

	localparam res_tab_t BYTE_RES = build_byte_res();

endpackage

FILE: src/qpht_front.sv
// ----------------------------------------------------------------------------
// Hash table front end
// Accepts transactions, normalises the name and computes its home slot.
// ----------------------------------------------------------------------------
module qpht_front import qpht_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               command,
	input  logic [63:0]        name_low,
	input  logic [63:0]        name_high,
	input  logic [PHONE_W-1:0] phone,
	output logic               push,
	output qpht_item_t         push_item,
	input  logic               full
);

	logic               vld_s1;
	logic               cmd_s1;
	logic [63:0]        lo_s1;
	logic [63:0]        hi_s1;
	logic [PHONE_W-1:0] phone_s1;

	logic               vld_s2;
	logic               cmd_s2;
	logic [127:0]       key_s2;
	logic [PHONE_W-1:0] phone_s2;
	logic [SUM_W-1:0]   sum_s2;

	logic               accept;
	logic               advance_s2;
	logic [127:0]       raw_w;
	logic [127:0]       norm_w;
	logic [IDX_W-1:0]   res [NAME_BYTES];
	logic [SUM_W-1:0]   pair [NAME_BYTES/2];
	logic [SUM_W-1:0]   quad [NAME_BYTES/4];
	logic [SUM_W-1:0]   sum_w;
	logic [SUM_W-1:0]   red_w;
	logic               ended;

	assign push       = vld_s2 && !full;
	assign advance_s2 = !vld_s2 || push;
	assign busy       = vld_s1 && !advance_s2;
	assign accept     = start && !busy;
	assign raw_w      = {hi_s1, lo_s1};

	always_comb begin
		ended = 1'b0;
		for (int k = 0; k < NAME_BYTES; k++) begin
			if (k >= NAME_CHARS || raw_w[k*8 +: 8] == 8'd0) begin
				ended = 1'b1;
			end
			norm_w[k*8 +: 8] = ended ? 8'd0 : raw_w[k*8 +: 8];
			res[k]           = ended ? '0 : BYTE_RES[raw_w[k*8 +: 8]];
		end
	end

	always_comb begin
		for (int k = 0; k < NAME_BYTES/2; k++) begin
			pair[k] = SUM_W'(res[2*k]) + SUM_W'(res[2*k+1]);
		end
		for (int k = 0; k < NAME_BYTES/4; k++) begin
			quad[k] = pair[2*k] + pair[2*k+1];
		end
		sum_w = quad[0] + quad[1] + quad[2] + quad[3];
	end

	always_comb begin
		red_w = sum_s2;
		for (int k = 3; k >= 0; k--) begin
			if (red_w >= (SUM_W'(TABLE_SIZE) << k)) begin
				red_w = red_w - (SUM_W'(TABLE_SIZE) << k);
			end
		end
	end

	always_comb begin
		push_item.command  = cmd_s2;
		push_item.key_low  = key_s2[63:0];
		push_item.key_high = key_s2[127:64];
		push_item.phone    = phone_s2;
		push_item.home     = red_w[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= accept || (vld_s1 && !advance_s2);
			vld_s2 <= (vld_s1 && advance_s2) || (vld_s2 && !push);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= command;
			lo_s1    <= name_low;
			hi_s1    <= name_high;
			phone_s1 <= phone;
		end
		if (vld_s1 && advance_s2) begin
			cmd_s2   <= cmd_s1;
			key_s2   <= norm_w;
			phone_s2 <= phone_s1;
			sum_s2   <= sum_w;
		end
	end

endmodule

FILE: src/qpht_queue.sv
// ----------------------------------------------------------------------------
// Hash table transaction queue
// A short first-in first-out queue between the front end and the probe engine.
// ----------------------------------------------------------------------------
module qpht_queue import qpht_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  qpht_item_t push_item,
	output logic       full,
	input  logic       pop,
	output qpht_item_t pop_item,
	output logic       avail
);

	qpht_item_t        entries [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full     = count_q == QCNT_W'(QUEUE_DEPTH);
	assign avail    = count_q != '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && avail;
	assign pop_item = entries[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries[wr_ptr_q] <= push_item;
		end
	end

endmodule

FILE: src/qpht_back.sv
// ----------------------------------------------------------------------------
// Hash table probe engine
// Walks the quadratic probe sequence one slot per cycle for inserts and
// searches, and holds the key and phone stores and the valid marks.
// ----------------------------------------------------------------------------
module qpht_back import qpht_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               avail,
	input  qpht_item_t         item,
	output logic               pop,
	output logic               done,
	output logic [1:0]         status,
	output logic [SLOT_W-1:0]  slot,
	output logic [PHONE_W-1:0] found_phone
);

	typedef enum logic [1:0] {
		IDLE,
		INSERT,
		SEARCH
	} state_t;

	function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
		logic [SLOT_W-1:0] r;
		r = '0;
		for (int b = 0; b < SLOT_W; b++) begin
			if (b < IDX_W) begin
				r[b] = idx[b];
			end
		end
		return r;
	endfunction

	logic [63:0]        key_low_mem  [TABLE_SIZE];
	logic [63:0]        key_high_mem [TABLE_SIZE];
	logic [PHONE_W-1:0] phone_mem    [TABLE_SIZE];
	logic [TABLE_SIZE-1:0] valid_q;

	state_t             state_q;
	qpht_item_t         item_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   odd_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               done_q;
	logic [1:0]         status_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [PHONE_W-1:0] phone_q;

	logic               rd_vld_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic               rd_used_s1;
	logic               rd_last_s1;
	logic [63:0]        rd_low_s1;
	logic [63:0]        rd_high_s1;
	logic [PHONE_W-1:0] rd_phone_s1;

	logic [IDX_W:0]     idx_sum;
	logic [IDX_W:0]     odd_sum;
	logic [IDX_W-1:0]   nxt_idx;
	logic [IDX_W-1:0]   nxt_odd;
	logic               slot_free;
	logic               last_probe;
	logic               ins_wr;
	logic               match;
	logic               srch_done;
	logic               issue;

	assign idx_sum = {1'b0, idx_q} + {1'b0, odd_q};
	assign odd_sum = {1'b0, odd_q} + (IDX_W+1)'(2);
	assign nxt_idx = (idx_sum >= (IDX_W+1)'(TABLE_SIZE)) ?
		IDX_W'(idx_sum - (IDX_W+1)'(TABLE_SIZE)) : idx_sum[IDX_W-1:0];
	assign nxt_odd = (odd_sum >= (IDX_W+1)'(TABLE_SIZE)) ?
		IDX_W'(odd_sum - (IDX_W+1)'(TABLE_SIZE)) : odd_sum[IDX_W-1:0];

	assign slot_free  = !valid_q[idx_q];
	assign last_probe = cnt_q == CNT_W'(TABLE_SIZE - 1);
	assign ins_wr     = (state_q == INSERT) && slot_free;
	assign match      = (rd_low_s1 == item_q.key_low) && (rd_high_s1 == item_q.key_high);
	assign srch_done  = rd_vld_s1 && (!rd_used_s1 || match || rd_last_s1);
	assign issue      = (state_q == SEARCH) && (cnt_q != CNT_W'(TABLE_SIZE)) && !srch_done;
	assign pop        = (state_q == IDLE) && avail;

	assign done        = done_q;
	assign status      = status_q;
	assign slot        = slot_q;
	assign found_phone = phone_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			valid_q   <= '0;
			idx_q     <= '0;
			odd_q     <= '0;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
			status_q  <= ST_STORED;
			slot_q    <= '0;
			phone_q   <= '0;
		end else begin
			done_q    <= 1'b0;
			rd_vld_s1 <= issue;
			unique case (state_q)
				IDLE: begin
					if (avail) begin
						idx_q   <= item.home;
						odd_q   <= IDX_W'(1);
						cnt_q   <= '0;
						state_q <= (item.command == CMD_SEARCH) ? SEARCH : INSERT;
					end
				end
				INSERT: begin
					if (slot_free) begin
						valid_q[idx_q] <= 1'b1;
						done_q         <= 1'b1;
						status_q       <= ST_STORED;
						slot_q         <= slot_of(idx_q);
						phone_q        <= '0;
						state_q        <= IDLE;
					end else if (last_probe) begin
						done_q   <= 1'b1;
						status_q <= ST_FULL;
						slot_q   <= '0;
						phone_q  <= '0;
						state_q  <= IDLE;
					end else begin
						idx_q <= nxt_idx;
						odd_q <= nxt_odd;
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				SEARCH: begin
					if (srch_done) begin
						done_q  <= 1'b1;
						state_q <= IDLE;
						if (rd_used_s1 && match) begin
							status_q <= ST_FOUND;
							slot_q   <= slot_of(rd_idx_s1);
							phone_q  <= rd_phone_s1;
						end else begin
							status_q <= ST_MISSING;
							slot_q   <= '0;
							phone_q  <= '0;
						end
					end else if (issue) begin
						idx_q <= nxt_idx;
						odd_q <= nxt_odd;
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= item;
		end
		if (ins_wr) begin
			key_low_mem[idx_q]  <= item_q.key_low;
			key_high_mem[idx_q] <= item_q.key_high;
			phone_mem[idx_q]    <= item_q.phone;
		end
		if (issue) begin
			rd_low_s1   <= key_low_mem[idx_q];
			rd_high_s1  <= key_high_mem[idx_q];
			rd_phone_s1 <= phone_mem[idx_q];
			rd_idx_s1   <= idx_q;
			rd_used_s1  <= valid_q[idx_q];
			rd_last_s1  <= last_probe;
		end
	end

endmodule

FILE: src/quadratic_probe_hash_table.sv
// ----------------------------------------------------------------------------
// Quadratic probe hash table
// Name keyed table of phone numbers with open addressing and quadratic probing.
// ----------------------------------------------------------------------------
// Throughput: the probe engine visits one slot per cycle and works on one
// transaction at a time; the front end and queue overlap with it.
// Reset clears the valid marks at once; stored keys and phones stay undefined.
// Results are strobed for one cycle and the receiver cannot stall them.
module quadratic_probe_hash_table import qpht_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               command,
	input  logic [63:0]        name_low,
	input  logic [63:0]        name_high,
	input  logic [PHONE_W-1:0] phone,
	output logic               done,
	output logic [1:0]         status,
	output logic [SLOT_W-1:0]  slot,
	output logic [PHONE_W-1:0] found_phone
);

	logic       push;
	qpht_item_t push_item;
	logic       full;
	logic       pop;
	qpht_item_t pop_item;
	logic       avail;

	qpht_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.command   (command),
		.name_low  (name_low),
		.name_high (name_high),
		.phone     (phone),
		.push      (push),
		.push_item (push_item),
		.full      (full)
	);

	qpht_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_item  (pop_item),
		.avail     (avail)
	);

	qpht_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.avail       (avail),
		.item        (pop_item),
		.pop         (pop),
		.done        (done),
		.status      (status),
		.slot        (slot),
		.found_phone (found_phone)
	);

endmodule
